// ----- src/dpq_pkg.sv -----
package dpq_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned CountWidth = 11;

  typedef logic signed [ValueWidth-1:0] key_t;
  typedef logic [CountWidth-1:0] count_out_t;

  typedef enum logic [1:0] {
    OP_INSERT         = 2'd0,
    OP_REMOVE_LARGEST = 2'd1,
    OP_REMOVE_SMALLEST = 2'd2,
    OP_CLEAR          = 2'd3
  } op_t;

  // one-cycle command broadcast to every cell of a chain
  typedef struct packed {
    logic ins;
    logic pop_front;
    logic pop_back;
    logic clr;
  } chain_cmd_t;

  // contents of one cell as seen by its neighbors
  typedef struct packed {
    logic valid;
    key_t key;
  } link_t;

endpackage

// ----- src/dpq_cell.sv -----
module dpq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  dpq_pkg::chain_cmd_t cmd,
  input  dpq_pkg::key_t      new_key,
  input  dpq_pkg::link_t     left,
  input  logic               left_gt,
  input  dpq_pkg::link_t     right,
  output dpq_pkg::link_t     cur,
  output logic               gt
);
  import dpq_pkg::*;

  logic valid_r;
  logic valid_nxt;
  key_t key_r;
  key_t key_nxt;

  assign cur.valid = valid_r;
  assign cur.key   = key_r;

  // empty cells count as greater so the insert point is the first such cell
  assign gt = !valid_r || (key_r > new_key);

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    if (cmd.clr) begin
      valid_nxt = 1'b0;
    end else if (cmd.ins) begin
      if (gt) begin
        if (left_gt) begin
          valid_nxt = left.valid;
          key_nxt   = left.key;
        end else begin
          valid_nxt = 1'b1;
          key_nxt   = new_key;
        end
      end
    end else if (cmd.pop_front) begin
      valid_nxt = right.valid;
      key_nxt   = right.key;
    end else if (cmd.pop_back) begin
      // last occupied cell drops out
      if (!right.valid) begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

// ----- src/dpq_chain.sv -----
module dpq_chain #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dpq_pkg::chain_cmd_t cmd,
  input  dpq_pkg::key_t      new_key,
  output dpq_pkg::link_t     head
);
  import dpq_pkg::*;

  link_t cells [DEPTH];
  logic  gts   [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    link_t left_link;
    link_t right_link;
    logic  left_gt;

    if (i == 0) begin : g_first
      assign left_link = '0;
      assign left_gt   = 1'b0;
    end else begin : g_mid_left
      assign left_link = cells[i-1];
      assign left_gt   = gts[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_link = '0;
    end else begin : g_mid_right
      assign right_link = cells[i+1];
    end

    dpq_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd),
      .new_key (new_key),
      .left    (left_link),
      .left_gt (left_gt),
      .right   (right_link),
      .cur     (cells[i]),
      .gt      (gts[i])
    );
  end

  assign head = cells[0];

endmodule

// ----- src/double_ended_priority_queue_core.sv -----
// channel  | ports                                           | handshake
// ---------+-------------------------------------------------+-------------------------
// input    | in_opcode, in_value                             | taken when start & !busy
// result   | out_is_empty, out_largest, out_smallest,        | out_valid for one cycle,
//          | out_overflow, out_entry_count                   | no back-pressure
//
// each item's result shows in the cycle after it is taken
// busy never rises, so an item can be taken in every cycle
// all cells of both chains update in the same cycle, each from its neighbors
// synchronous active-low reset empties the queue; no clearing pass is needed
// the receiver cannot stall, so no result is ever held back
module double_ended_priority_queue_core #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_opcode,
  input  dpq_pkg::key_t         in_value,
  output logic                  out_valid,
  output logic                  out_is_empty,
  output dpq_pkg::key_t         out_largest,
  output dpq_pkg::key_t         out_smallest,
  output logic                  out_overflow,
  output dpq_pkg::count_out_t   out_entry_count
);
  import dpq_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(CAPACITY);

  // low chain holds values ascending, high chain holds inverted values
  // ascending; inverting reverses signed order, so each head is one extreme

  op_t            op;
  logic           accept;
  logic           full;
  logic           empty;
  chain_cmd_t     cmd_lo;
  chain_cmd_t     cmd_hi;
  link_t          head_lo;
  link_t          head_hi;

  logic [CntW-1:0] count_r;
  logic [CntW-1:0] count_nxt;
  logic            out_valid_r;
  logic            overflow_r;
  logic            overflow_nxt;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign op     = op_t'(in_opcode);
  assign full   = (count_r == CntFull);
  assign empty  = (count_r == '0);

  // command decode; inserts into a full queue are dropped
  always_comb begin
    cmd_lo = '0;
    cmd_hi = '0;
    overflow_nxt = 1'b0;
    count_nxt = count_r;
    if (accept) begin
      case (op)
        OP_INSERT: begin
          if (full) begin
            overflow_nxt = 1'b1;
          end else begin
            cmd_lo.ins = 1'b1;
            cmd_hi.ins = 1'b1;
            count_nxt  = count_r + CntW'(1);
          end
        end
        OP_REMOVE_LARGEST: begin
          if (!empty) begin
            // largest is the head of the high chain, tail of the low chain
            cmd_hi.pop_front = 1'b1;
            cmd_lo.pop_back  = 1'b1;
            count_nxt = count_r - CntW'(1);
          end
        end
        OP_REMOVE_SMALLEST: begin
          if (!empty) begin
            cmd_lo.pop_front = 1'b1;
            cmd_hi.pop_back  = 1'b1;
            count_nxt = count_r - CntW'(1);
          end
        end
        OP_CLEAR: begin
          cmd_lo.clr = 1'b1;
          cmd_hi.clr = 1'b1;
          count_nxt  = '0;
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
    end
  end

  dpq_chain #(
    .DEPTH (CAPACITY)
  ) u_chain_lo (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd_lo),
    .new_key (in_value),
    .head    (head_lo)
  );

  dpq_chain #(
    .DEPTH (CAPACITY)
  ) u_chain_hi (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd_hi),
    .new_key (~in_value),
    .head    (head_hi)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
      overflow_r  <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
      overflow_r  <= overflow_nxt;
    end
  end

  // chains and count already hold the state after the item
  assign out_valid       = out_valid_r;
  assign out_is_empty    = empty;
  assign out_smallest    = head_lo.valid ? head_lo.key : '0;
  assign out_largest     = head_hi.valid ? ~head_hi.key : '0;
  assign out_overflow    = overflow_r;
  assign out_entry_count = count_out_t'(count_r);

  // both chains agree on occupancy with the count
  a_heads_match: assert property (@(posedge clk) disable iff (!rst_n)
    head_lo.valid == head_hi.valid)
    else $error("chain heads disagree on occupancy");

  a_count_head: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) == !head_lo.valid)
    else $error("count and low chain head disagree");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    head_lo.valid |-> (head_lo.key <= ~head_hi.key))
    else $error("smallest exceeds largest");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && op == OP_CLEAR) |=> (count_r == '0 && !head_lo.valid))
    else $error("clear left entries behind");

  a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    overflow_nxt |-> (full && !cmd_lo.ins && count_nxt == count_r))
    else $error("dropped insert changed the queue");

endmodule

// ----- dv/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dpq_pkg::*;

  // queue depth of the instance under test, left at the block's default
  localparam int unsigned QueueDepth = 1024;
  // random items outside the fill-and-drain run
  localparam int unsigned RandomItems = 450;

  localparam key_t KeyMax = 32'sh7fffffff;
  localparam key_t KeyMin = 32'sh80000000;
  localparam key_t KeyNegOne = -32'sd1;

  // everything the block reports after one item
  typedef struct packed {
    logic       is_empty;
    key_t       largest;
    key_t       smallest;
    logic       overflow;
    count_out_t entry_count;
  } pq_status_t;

  localparam pq_status_t EmptyStatus = '{1'b1, '0, '0, 1'b0, '0};

  // one row of the directed table; typed rows carry their own expected status
  typedef struct packed {
    op_t        op;
    key_t       value;
    logic       typed;
    pq_status_t status;
  } dir_row_t;

  localparam int unsigned NumDirected = 25;

  dir_row_t directed_rows [NumDirected] = '{
    // removals and clear on an empty queue change nothing
    '{OP_REMOVE_LARGEST, 32'sd0, 1'b1, EmptyStatus},
    '{OP_REMOVE_SMALLEST, 32'sh1234, 1'b1, EmptyStatus},
    '{OP_CLEAR, KeyNegOne, 1'b1, EmptyStatus},
    // both extremes, then a duplicate of the smallest
    '{OP_INSERT, KeyMax, 1'b1, '{1'b0, KeyMax, KeyMax, 1'b0, 11'd1}},
    '{OP_INSERT, KeyMin, 1'b1, '{1'b0, KeyMax, KeyMin, 1'b0, 11'd2}},
    '{OP_INSERT, KeyMin, 1'b1, '{1'b0, KeyMax, KeyMin, 1'b0, 11'd3}},
    '{OP_INSERT, KeyNegOne, 1'b1, '{1'b0, KeyMax, KeyMin, 1'b0, 11'd4}},
    '{OP_INSERT, 32'sd0, 1'b1, '{1'b0, KeyMax, KeyMin, 1'b0, 11'd5}},
    // a duplicate smallest leaves one copy behind
    '{OP_REMOVE_SMALLEST, 32'sd0, 1'b1, '{1'b0, KeyMax, KeyMin, 1'b0, 11'd4}},
    '{OP_REMOVE_SMALLEST, 32'sd0, 1'b1, '{1'b0, KeyMax, KeyNegOne, 1'b0, 11'd3}},
    '{OP_REMOVE_LARGEST, 32'sd0, 1'b1, '{1'b0, 32'sd0, KeyNegOne, 1'b0, 11'd2}},
    // alternating bit patterns
    '{OP_INSERT, 32'sh55555555, 1'b0, EmptyStatus},
    '{OP_INSERT, 32'shaaaaaaaa, 1'b0, EmptyStatus},
    // equal values below the largest
    '{OP_INSERT, 32'sd5, 1'b0, EmptyStatus},
    '{OP_INSERT, 32'sd5, 1'b0, EmptyStatus},
    '{OP_REMOVE_LARGEST, KeyMax, 1'b0, EmptyStatus},
    '{OP_REMOVE_LARGEST, KeyMin, 1'b0, EmptyStatus},
    '{OP_REMOVE_SMALLEST, 32'sh0f0f0f0f, 1'b0, EmptyStatus},
    '{OP_REMOVE_SMALLEST, 32'shf0f0f0f0, 1'b0, EmptyStatus},
    '{OP_REMOVE_SMALLEST, 32'sd0, 1'b0, EmptyStatus},
    // the last entry goes, then a removal on the now empty queue
    '{OP_REMOVE_LARGEST, 32'sd0, 1'b0, EmptyStatus},
    '{OP_REMOVE_LARGEST, 32'sd0, 1'b0, EmptyStatus},
    '{OP_INSERT, KeyMin, 1'b0, EmptyStatus},
    '{OP_INSERT, KeyMax, 1'b0, EmptyStatus},
    '{OP_CLEAR, KeyMax, 1'b1, EmptyStatus}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] in_opcode = OP_INSERT;
  key_t       in_value = '0;
  logic       out_valid;
  logic       out_is_empty;
  key_t       out_largest;
  key_t       out_smallest;
  logic       out_overflow;
  count_out_t out_entry_count;

  // live values held by the queue, in no particular order
  key_t held_keys [$];
  // status still owed by the block, oldest first
  pq_status_t status_due [$];
  int unsigned error_count = 0;

  double_ended_priority_queue_core #(
    .CAPACITY(QueueDepth)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_opcode(in_opcode),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_is_empty(out_is_empty),
    .out_largest(out_largest),
    .out_smallest(out_smallest),
    .out_overflow(out_overflow),
    .out_entry_count(out_entry_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // hard stop well past the slowest correct run
  initial begin
    #2_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  // index of the largest (or smallest) held value; the queue must not be empty
  function automatic int extreme_index(input bit want_largest);
    int best;
    best = 0;
    for (int i = 1; i < held_keys.size(); i++) begin
      if (want_largest ? (held_keys[i] > held_keys[best])
                       : (held_keys[i] < held_keys[best])) begin
        best = i;
      end
    end
    return best;
  endfunction

  // apply one item to the queue contents and return the status that follows
  function automatic pq_status_t next_status(input op_t op, input key_t value);
    pq_status_t st;
    st = EmptyStatus;
    case (op)
      OP_INSERT: begin
        if (held_keys.size() >= QueueDepth) st.overflow = 1'b1;
        else held_keys.push_back(value);
      end
      OP_REMOVE_LARGEST, OP_REMOVE_SMALLEST: begin
        if (held_keys.size() != 0) held_keys.delete(extreme_index(op == OP_REMOVE_LARGEST));
      end
      default: begin
        held_keys.delete();
      end
    endcase
    st.entry_count = count_out_t'(held_keys.size());
    if (held_keys.size() != 0) begin
      st.is_empty = 1'b0;
      st.largest = held_keys[extreme_index(1'b1)];
      st.smallest = held_keys[extreme_index(1'b0)];
    end
    return st;
  endfunction

  // mostly no gap, some short ones, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // grow_pct sets how much of the mix is inserts; clear stays rare
  function automatic op_t pick_op(input int unsigned grow_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 2) return OP_CLEAR;
    if (r < 2 + grow_pct) return OP_INSERT;
    return ($urandom_range(0, 1) != 0) ? OP_REMOVE_LARGEST : OP_REMOVE_SMALLEST;
  endfunction

  // values: a narrow pool for duplicates, extremes, a small range around zero, or any 32-bit pattern
  function automatic key_t pick_key(input bit dup_pool);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (dup_pool || r < 2) return key_t'(int'($urandom_range(0, 6)) - 3);
    case (r)
      2: return KeyMax;
      3: return KeyMin;
      4: return key_t'(int'($urandom_range(0, 2000)) - 1000);
      default: return key_t'($urandom);
    endcase
  endfunction

  // offer one item, wait for it to be taken, then idle for gap cycles;
  // the expected status is the typed one when given, else the predicted one
  task automatic push_item(input op_t op, input key_t value, input logic typed,
                           input pq_status_t typed_status, input int unsigned gap);
    pq_status_t predicted;
    in_opcode <= op;
    in_value <= value;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = next_status(op, value);
    status_due.push_back(typed ? typed_status : predicted);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // result checking: every strobe is matched against the oldest expectation
  always @(posedge clk) begin
    pq_status_t want;
    if (rst_n && out_valid) begin
      if (status_due.size() == 0) begin
        report_mismatch("result with no item waiting");
      end else begin
        want = status_due.pop_front();
        if (out_is_empty !== want.is_empty)
          report_mismatch($sformatf("is_empty %b, want %b", out_is_empty, want.is_empty));
        if (out_largest !== want.largest)
          report_mismatch($sformatf("largest %0d, want %0d", out_largest, want.largest));
        if (out_smallest !== want.smallest)
          report_mismatch($sformatf("smallest %0d, want %0d", out_smallest, want.smallest));
        if (out_overflow !== want.overflow)
          report_mismatch($sformatf("overflow %b, want %b", out_overflow, want.overflow));
        if (out_entry_count !== want.entry_count)
          report_mismatch($sformatf("entry_count %0d, want %0d",
                                    out_entry_count, want.entry_count));
      end
    end
  end

  initial begin
    int unsigned random_count;
    int unsigned burst_len;
    int unsigned grow_pct;
    bit          dup_pool;
    bit          no_idle;
    bit          fill_done;
    int unsigned settle;

    random_count = 0;
    fill_done = 1'b0;

    // reset held at the start, once
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed table: extremes, duplicates, empty-queue removals, clear
    foreach (directed_rows[i]) begin
      push_item(directed_rows[i].op, directed_rows[i].value, directed_rows[i].typed,
                directed_rows[i].status, pick_gap());
    end

    // random bursts: growing or shrinking mixes, some from a narrow value pool
    while (random_count < RandomItems) begin
      burst_len = $urandom_range(8, 60);
      grow_pct = ($urandom_range(0, 1) != 0) ? 60 : 30;
      dup_pool = ($urandom_range(0, 3) == 0);
      no_idle = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < burst_len; k++) begin
        push_item(pick_op(grow_pct), pick_key(dup_pool), 1'b0, EmptyStatus,
                  no_idle ? 0 : pick_gap());
        random_count++;
      end

      // once, halfway: fill to the brim, overflow, then drain to empty
      if (!fill_done && random_count >= RandomItems / 2) begin
        fill_done = 1'b1;
        while (held_keys.size() < QueueDepth) begin
          push_item(OP_INSERT, pick_key($urandom_range(0, 3) == 0), 1'b0, EmptyStatus,
                    ($urandom_range(0, 7) == 0) ? pick_gap() : 0);
        end
        // inserts into a full queue are dropped and flagged
        repeat (3) push_item(OP_INSERT, pick_key(1'b0), 1'b0, EmptyStatus, pick_gap());
        // one slot freed and refilled, then a further insert is dropped
        push_item(OP_REMOVE_SMALLEST, pick_key(1'b0), 1'b0, EmptyStatus, pick_gap());
        push_item(OP_INSERT, KeyMin, 1'b0, EmptyStatus, pick_gap());
        push_item(OP_INSERT, KeyMax, 1'b0, EmptyStatus, pick_gap());
        while (held_keys.size() != 0) begin
          push_item(($urandom_range(0, 1) != 0) ? OP_REMOVE_LARGEST : OP_REMOVE_SMALLEST,
                    pick_key(1'b0), 1'b0, EmptyStatus,
                    ($urandom_range(0, 7) == 0) ? pick_gap() : 0);
        end
        push_item(OP_REMOVE_LARGEST, pick_key(1'b0), 1'b0, EmptyStatus, pick_gap());
      end
    end

    start <= 1'b0;

    // drain: wait for every owed status, then let the settle period catch strays
    while (status_due.size() != 0) @(posedge clk);
    settle = 4;
    repeat (settle) @(posedge clk);

    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
